@@ src/assert_macros.svh @@
// Assertion macros shared by the quantile stats RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define PQS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pqs assertion failed");

// Next-cycle implication, masked while reset is high.
`define PQS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pqs assertion failed");

`endif

@@ src/pqs_pkg.sv @@
// Shared constants and types for the quantile stats block.
package pqs_pkg;

   localparam int unsigned MAX_ENTRIES = 4096;

   localparam int unsigned PROB_W  = 17;
   localparam int unsigned LEVEL_W = 17;
   localparam int unsigned SUM_W   = 18;
   localparam int unsigned IDX_W   = 12;
   localparam int unsigned COUNT_W = 13;
   localparam int unsigned CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned NUM_SLOTS = 4;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 64;

   localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST  = 17'd3277;
   localparam logic [LEVEL_W-1:0] MID_LEVEL_RST  = 17'd32768;
   localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST = 17'd62259;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LOW_LEVEL  = 2'd0,
      CSR_MID_LEVEL  = 2'd1,
      CSR_HIGH_LEVEL = 2'd2
   } csr_addr_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] low;
      logic [LEVEL_W-1:0] mid;
      logic [LEVEL_W-1:0] high;
   } levels_type;

   typedef struct packed {
      logic               overflow;
      logic [COUNT_W-1:0] entry_count;
      logic [IDX_W-1:0]   high_quantile_index;
      logic [IDX_W-1:0]   median_index;
      logic [IDX_W-1:0]   low_quantile_index;
      logic [IDX_W-1:0]   min_index;
   } result_type;

endpackage

@@ src/pdf_quantile_stats.sv @@
// Top level of the streamed distribution quantile stats block.
//
// Usage:
//  req channel: one probability entry per word, in index order. tdata[16:0]
//  is the probability (unsigned, 1.0 = 65536); tlast marks the last entry.
//  rsp channel: one word per distribution, issued for the tlast entry only.
//  csr channel: writes the three quantile levels (index 0 low, 1 mid, 2 high);
//  always ready, write only while the block is idle.
// Path: a last entry goes from the input register into the result register,
// which drives rsp; while that slot is busy, it waits in the input register.
// Throughput: one word per cycle on req unless a last word waits for rsp;
// the sum, saturation, min and three level compares: one stage past input reg.
// Stall: while a result waits on rsp, non-last entries keep flowing; a second
// last entry waits in the input register, then req_tready drops.
// Reset: sum, counts and marks clear, levels return to about 5%, 50%, 95%;
// no word is in flight. After each result the tracking state clears again.
// Entries beyond MAX_ENTRIES are not summed and set the overflow bit.
module pdf_quantile_stats import pqs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // req: tdata = probability[16:0], zero padded to 24 bits
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   // rsp: tdata = min_index[11:0], low_quantile_index[23:12],
   // median_index[35:24], high_quantile_index[47:36], entry_count[60:48],
   // overflow[61], zero padding[63:62]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // csr: register index and 17-bit level
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [LEVEL_W-1:0]    csr_wdata
);

   levels_type levels;
   result_type res_data;
   logic       res_load;
   logic       slot_free;

   // level registers
   pqs_levels u_levels (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .levels    (levels)
   );

   // input register and running statistics
   pqs_track u_track (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_prob   (req_tdata[PROB_W-1:0]),
      .in_last   (req_tlast),
      .levels    (levels),
      .slot_free (slot_free),
      .res_load  (res_load),
      .res_data  (res_data)
   );

   // result word register
   pqs_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_load),
      .data       (res_data),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ src/pqs_levels.sv @@
// Quantile level registers written through the csr channel.
module pqs_levels import pqs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [LEVEL_W-1:0]    csr_wdata,
   output levels_type            levels
);

   levels_type levels_ff, levels_in;

   assign csr_ready = 1'b1;
   assign levels    = levels_ff;

   always_comb begin
      levels_in = levels_ff;
      if (csr_valid) begin
         case (csr_addr)
            CSR_LOW_LEVEL:  levels_in.low  = csr_wdata;
            CSR_MID_LEVEL:  levels_in.mid  = csr_wdata;
            CSR_HIGH_LEVEL: levels_in.high = csr_wdata;
            default:        levels_in = levels_ff;  // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff.low  <= LOW_LEVEL_RST;
         levels_ff.mid  <= MID_LEVEL_RST;
         levels_ff.high <= HIGH_LEVEL_RST;
      end else begin
         levels_ff <= levels_in;
      end
   end

endmodule

@@ src/pqs_track.sv @@
// Input register plus running sum, quantile marks and entry count.
`include "assert_macros.svh"

module pqs_track import pqs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [PROB_W-1:0] in_prob,
   input  logic              in_last,
   input  levels_type        levels,
   input  logic              slot_free,
   output logic              res_load,
   output result_type        res_data
);

   logic              in_vld_ff, in_vld_in;
   logic [PROB_W-1:0] prob_ff, prob_in;
   logic              last_ff, last_in;

   logic [SUM_W-1:0]  running_sum_ff, running_sum_in;
   logic [CNT_W-1:0]  entry_index_ff, entry_index_in;
   logic [NUM_SLOTS-1:0] found_marks_ff, found_marks_in;
   logic [IDX_W-1:0]  found_idx_ff [NUM_SLOTS];
   logic [IDX_W-1:0]  found_idx_in [NUM_SLOTS];
   logic              overflow_ff, overflow_in;

   logic              advance;
   logic              has_room;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  upd_sum;
   logic [CNT_W-1:0]  upd_index;
   logic [NUM_SLOTS-1:0] upd_marks;
   logic [IDX_W-1:0]  upd_idx [NUM_SLOTS];
   logic              upd_overflow;
   logic [SUM_W-1:0]  thr [NUM_SLOTS];
   logic              state_idle;
   logic              sum_nonzero;

   // a last word must find the result slot free; others always move on
   assign advance  = in_vld_ff && (!last_ff || slot_free);
   assign in_ready = !in_vld_ff || advance;
   assign res_load = advance && last_ff;

   // min mark is "sum reached one", the rest follow the levels
   assign thr[0] = SUM_W'(1);
   assign thr[1] = SUM_W'(levels.low);
   assign thr[2] = SUM_W'(levels.mid);
   assign thr[3] = SUM_W'(levels.high);

   assign has_room = entry_index_ff < CNT_W'(MAX_ENTRIES);
   assign sum_wide = {1'b0, running_sum_ff} + (SUM_W+1)'(prob_ff);

   always_comb begin
      upd_sum      = running_sum_ff;
      upd_index    = entry_index_ff;
      upd_marks    = found_marks_ff;
      upd_overflow = overflow_ff;
      for (int i = 0; i < NUM_SLOTS; i++) upd_idx[i] = found_idx_ff[i];
      if (has_room) begin
         upd_sum   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
         upd_index = entry_index_ff + CNT_W'(1);
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found_marks_ff[i] && (upd_sum >= thr[i])) begin
               upd_marks[i] = 1'b1;
               upd_idx[i]   = IDX_W'(entry_index_ff);
            end
         end
      end else begin
         upd_overflow = 1'b1;
      end
   end

   always_comb begin
      res_data.min_index           = upd_marks[0] ? upd_idx[0] : '0;
      res_data.low_quantile_index  = upd_marks[1] ? upd_idx[1] : '0;
      res_data.median_index        = upd_marks[2] ? upd_idx[2] : '0;
      res_data.high_quantile_index = upd_marks[3] ? upd_idx[3] : '0;
      res_data.entry_count         = COUNT_W'(upd_index);
      res_data.overflow            = upd_overflow;
   end

   always_comb begin
      in_vld_in = in_vld_ff;
      prob_in   = prob_ff;
      last_in   = last_ff;
      if (in_valid && in_ready) begin
         in_vld_in = 1'b1;
         prob_in   = in_prob;
         last_in   = in_last;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      running_sum_in = running_sum_ff;
      entry_index_in = entry_index_ff;
      found_marks_in = found_marks_ff;
      overflow_in    = overflow_ff;
      for (int i = 0; i < NUM_SLOTS; i++) found_idx_in[i] = found_idx_ff[i];
      if (advance) begin
         if (last_ff) begin
            running_sum_in = '0;
            entry_index_in = '0;
            found_marks_in = '0;
            overflow_in    = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) found_idx_in[i] = '0;
         end else begin
            running_sum_in = upd_sum;
            entry_index_in = upd_index;
            found_marks_in = upd_marks;
            overflow_in    = upd_overflow;
            for (int i = 0; i < NUM_SLOTS; i++) found_idx_in[i] = upd_idx[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      prob_ff <= prob_in;
      last_ff <= last_in;
      if (reset) begin
         in_vld_ff      <= 1'b0;
         running_sum_ff <= '0;
         entry_index_ff <= '0;
         found_marks_ff <= '0;
         overflow_ff    <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) found_idx_ff[i] <= '0;
      end else begin
         in_vld_ff      <= in_vld_in;
         running_sum_ff <= running_sum_in;
         entry_index_ff <= entry_index_in;
         found_marks_ff <= found_marks_in;
         overflow_ff    <= overflow_in;
         for (int i = 0; i < NUM_SLOTS; i++) found_idx_ff[i] <= found_idx_in[i];
      end
   end

   assign state_idle  = (entry_index_ff == '0) && (found_marks_ff == '0) &&
                        (running_sum_ff == '0);
   assign sum_nonzero = running_sum_ff != '0;

   `PQS_ASSERT_NXT(a_clear_after_last, clock, reset, res_load, state_idle)
   `PQS_ASSERT_IMP(a_marks_need_entries, clock, reset, found_marks_ff != '0, entry_index_ff != '0)
   `PQS_ASSERT_IMP(a_min_mark_tracks_sum, clock, reset, 1'b1, found_marks_ff[0] == sum_nonzero)

endmodule

@@ src/pqs_out.sv @@
// Result register holding one word towards the rsp channel.
`include "assert_macros.svh"

module pqs_out import pqs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  result_type            data,
   output logic                  slot_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       vld_ff, vld_in;
   result_type data_ff, data_in;

   assign slot_free  = !vld_ff || rsp_tready;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = RSP_DATA_W'(data_ff);

   always_comb begin
      vld_in  = vld_ff;
      data_in = data_ff;
      if (load) begin
         vld_in  = 1'b1;
         data_in = data;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   `PQS_ASSERT_IMP(a_load_into_free_slot, clock, reset, load, !vld_ff || rsp_tready)

endmodule
